FILE: src/ssb_pkg.sv
// Shared types and constants of the sporadic server budget keeper.
package ssb_pkg;

	localparam int unsigned CAP_W  = 24;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned USED_W = 24;
	localparam int unsigned BUD_W  = 32;

	localparam logic [CAP_W-1:0] RESET_CAPACITY = 24'd10000;
	localparam logic [CAP_W-1:0] RESET_PERIOD   = 24'd100000;

	// Function codes as they arrive on the request port.
	localparam logic [2:0] FUNC_ARRIVAL     = 3'd0;
	localparam logic [2:0] FUNC_DISPATCH    = 3'd1;
	localparam logic [2:0] FUNC_CHARGE      = 3'd2;
	localparam logic [2:0] FUNC_CAP_EXPIRED = 3'd3;
	localparam logic [2:0] FUNC_REPLENISH   = 3'd4;
	localparam logic [2:0] FUNC_BLOCK       = 3'd5;

	// Configuration register indexes.
	localparam logic CFG_CAPACITY = 1'b0;
	localparam logic CFG_PERIOD   = 1'b1;

	typedef enum logic [2:0] {
		OP_ARRIVAL,
		OP_DISPATCH,
		OP_CHARGE,
		OP_CAP_EXPIRED,
		OP_REPLENISH,
		OP_BLOCK,
		OP_NOP
	} op_t;

	typedef enum logic [1:0] {
		ERR_NONE,
		ERR_RING_FULL,
		ERR_INACTIVE,
		ERR_RING_EMPTY
	} err_t;

	typedef struct packed {
		op_t               op;
		logic [TIME_W-1:0] now_us;
		logic [USED_W-1:0] used_us;
		logic              background;
		logic              no_stop;
		logic              job_end;
		logic              next_ready;
		logic              server_idle;
		logic              task_waiting;
	} req_t;

	typedef struct packed {
		logic                     arm_replenish;
		logic [TIME_W-1:0]        replenish_deadline;
		logic                     arm_capacity;
		logic [TIME_W-1:0]        capacity_deadline;
		logic                     start_task;
		logic                     suspend_task;
		logic signed [BUD_W-1:0]  budget_left;
		logic                     forced_refill;
		err_t                     error_code;
	} result_t;

endpackage

FILE: src/sporadic_server_budget.sv
// Top level of the sporadic server budget keeper.
//
// This block keeps the remaining budget of a sporadic server, the execution
// time gathered since the server became active, an active flag and a ring of
// posted replenishment amounts, and turns each scheduler event request into
// one result request telling the scheduler which timers to arm, whether to
// start or suspend a task, and what budget is left. Requests enter on a
// valid/ready port; a front end decodes the function code and drops the
// request into a two-entry queue, so the port keeps accepting while the back
// end works or while a finished result waits to be taken. The back
// end handles one request at a time: it first reads the ring slot at the
// head from its memory, then updates budget, usage and ring state and loads
// the output register, waiting while a result is not taken. A request
// accepted on an idle block passes the queue, the ring read register and
// the output register before its result shows. Budget arithmetic saturates
// to the signed 32-bit range, posted amounts saturate at 2^32-1, and both
// timer deadlines wrap modulo 2^32. The user must write capacity and period
// through the configuration port only while no request is in flight; the
// block does not enforce this. Writing capacity does not touch the current
// budget. The ring holds RING_DEPTH amounts and its slots are not cleared at
// reset: each use of read data is guarded by the fill count, so no clearing
// pass is needed and the block takes requests right after reset.
module sporadic_server_budget #(
	parameter int unsigned RING_DEPTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,

	input  logic                        cfg_we,
	input  logic                        cfg_idx,
	input  logic [ssb_pkg::CAP_W-1:0]   cfg_wdata,

	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [2:0]                  func,
	input  logic [ssb_pkg::TIME_W-1:0]  now_us,
	input  logic [ssb_pkg::USED_W-1:0]  used_us,
	input  logic                        background,
	input  logic                        no_stop,
	input  logic                        job_end,
	input  logic                        next_ready,
	input  logic                        server_idle,
	input  logic                        task_waiting,

	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        arm_replenish,
	output logic [ssb_pkg::TIME_W-1:0]  replenish_deadline,
	output logic                        arm_capacity,
	output logic [ssb_pkg::TIME_W-1:0]  capacity_deadline,
	output logic                        start_task,
	output logic                        suspend_task,
	output logic signed [ssb_pkg::BUD_W-1:0] budget_left,
	output logic                        forced_refill,
	output logic [1:0]                  error_code
);

	logic [ssb_pkg::CAP_W-1:0] capacity_q;
	logic [ssb_pkg::CAP_W-1:0] period_q;

	logic             q_full;
	logic             q_push;
	ssb_pkg::req_t    q_in_req;
	logic             q_pop;
	logic             q_not_empty;
	ssb_pkg::req_t    q_out_req;
	ssb_pkg::result_t res;

	// Configuration registers. Both are plain write-only registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= ssb_pkg::RESET_CAPACITY;
			period_q   <= ssb_pkg::RESET_PERIOD;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				ssb_pkg::CFG_CAPACITY: capacity_q <= cfg_wdata;
				ssb_pkg::CFG_PERIOD:   period_q   <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Front end: request port and function decode.
	ssb_front u_front (
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.now_us       (now_us),
		.used_us      (used_us),
		.background   (background),
		.no_stop      (no_stop),
		.job_end      (job_end),
		.next_ready   (next_ready),
		.server_idle  (server_idle),
		.task_waiting (task_waiting),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_req        (q_in_req)
	);

	// The queue lets the front end keep taking requests while the back end
	// is busy or its result is stalled.
	ssb_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_req  (q_in_req),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_req   (q_out_req)
	);

	// Back end: all server state and the registered result.
	ssb_back #(
		.RING_DEPTH (RING_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.capacity    (capacity_q),
		.period      (period_q),
		.q_not_empty (q_not_empty),
		.q_req       (q_out_req),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.res         (res)
	);

	assign arm_replenish      = res.arm_replenish;
	assign replenish_deadline = res.replenish_deadline;
	assign arm_capacity       = res.arm_capacity;
	assign capacity_deadline  = res.capacity_deadline;
	assign start_task         = res.start_task;
	assign suspend_task       = res.suspend_task;
	assign budget_left        = res.budget_left;
	assign forced_refill      = res.forced_refill;
	assign error_code         = res.error_code;

endmodule

FILE: src/ssb_front.sv
// Front end: takes requests from the port and decodes the function code.
module ssb_front (
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [2:0]                  func,
	input  logic [ssb_pkg::TIME_W-1:0]  now_us,
	input  logic [ssb_pkg::USED_W-1:0]  used_us,
	input  logic                        background,
	input  logic                        no_stop,
	input  logic                        job_end,
	input  logic                        next_ready,
	input  logic                        server_idle,
	input  logic                        task_waiting,
	input  logic                        q_full,
	output logic                        q_push,
	output ssb_pkg::req_t               q_req
);

	ssb_pkg::op_t op;

	always_comb begin
		unique case (func)
			ssb_pkg::FUNC_ARRIVAL:     op = ssb_pkg::OP_ARRIVAL;
			ssb_pkg::FUNC_DISPATCH:    op = ssb_pkg::OP_DISPATCH;
			ssb_pkg::FUNC_CHARGE:      op = ssb_pkg::OP_CHARGE;
			ssb_pkg::FUNC_CAP_EXPIRED: op = ssb_pkg::OP_CAP_EXPIRED;
			ssb_pkg::FUNC_REPLENISH:   op = ssb_pkg::OP_REPLENISH;
			ssb_pkg::FUNC_BLOCK:       op = ssb_pkg::OP_BLOCK;
			default:                   op = ssb_pkg::OP_NOP;
		endcase
	end

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_req              = '0;
		q_req.op           = op;
		q_req.now_us       = now_us;
		q_req.used_us      = used_us;
		q_req.background   = background;
		q_req.no_stop      = no_stop;
		q_req.job_end      = job_end;
		q_req.next_ready   = next_ready;
		q_req.server_idle  = server_idle;
		q_req.task_waiting = task_waiting;
	end

endmodule

FILE: src/ssb_fifo.sv
// Two-entry queue of decoded requests between the front and back ends.
module ssb_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ssb_pkg::req_t push_req,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output ssb_pkg::req_t pop_req
);

	ssb_pkg::req_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_req   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

FILE: src/ssb_back.sv
// Back end: budget, usage and ring state, and the result register.
module ssb_back #(
	parameter int unsigned RING_DEPTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [ssb_pkg::CAP_W-1:0]   capacity,
	input  logic [ssb_pkg::CAP_W-1:0]   period,
	input  logic                        q_not_empty,
	input  ssb_pkg::req_t               q_req,
	output logic                        q_pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output ssb_pkg::result_t            res
);

	localparam int unsigned IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(RING_DEPTH);

	localparam logic signed [31:0] BUD_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] BUD_MIN = 32'sh8000_0000;

	// Ring of posted replenishment amounts.
	logic [31:0]       ring_mem [RING_DEPTH];
	logic [31:0]       ring_rdata_q;

	logic signed [31:0] budget_q;
	logic [31:0]        pending_q;
	logic               active_q;
	logic [IDX_W-1:0]   head_q;
	logic [IDX_W-1:0]   tail_q;
	logic [CNT_W-1:0]   count_q;

	ssb_pkg::req_t      req_s1;
	logic               valid_s1;

	ssb_pkg::result_t   res_q;
	logic               out_valid_q;

	logic               fire;
	logic               ring_full;

	logic [33:0]        diff34;
	logic signed [31:0] charge_budget;
	logic [32:0]        pend33;
	logic [31:0]        charge_pend;
	logic [33:0]        sum34;
	logic signed [31:0] rep_budget;
	logic               budget_pos;

	logic signed [31:0] nxt_budget;
	logic [31:0]        nxt_pend;
	logic               nxt_active;
	logic               push;
	logic [31:0]        push_amt;
	logic               pop;
	ssb_pkg::result_t   nxt_res;

	// A request is taken into the ring read register, then updated on fire.
	assign q_pop = q_not_empty && !valid_s1;
	assign fire  = valid_s1 && (!out_valid_q || out_ready);

	assign ring_full = (count_q == FULL_CNT);

	// Charge arithmetic: budget minus usage, saturated to the signed range.
	always_comb begin
		diff34 = {{2{budget_q[31]}}, budget_q} - {10'd0, req_s1.used_us};
		if (diff34[33:31] != {3{diff34[33]}}) begin
			charge_budget = diff34[33] ? BUD_MIN : BUD_MAX;
		end else begin
			charge_budget = diff34[31:0];
		end
		pend33 = {1'b0, pending_q} + {9'd0, req_s1.used_us};
		charge_pend = pend33[32] ? 32'hFFFF_FFFF : pend33[31:0];
	end

	// Replenish arithmetic: add the popped amount and clamp to capacity.
	always_comb begin
		sum34 = {{2{budget_q[31]}}, budget_q} + {2'b00, ring_rdata_q};
		if ($signed(sum34) > $signed({10'd0, capacity})) begin
			rep_budget = {8'd0, capacity};
		end else begin
			rep_budget = sum34[31:0];
		end
	end

	assign budget_pos = (budget_q > 32'sd0);

	always_comb begin
		nxt_budget = budget_q;
		nxt_pend   = pending_q;
		nxt_active = active_q;
		push       = 1'b0;
		push_amt   = '0;
		pop        = 1'b0;
		nxt_res    = '0;
		nxt_res.error_code = ssb_pkg::ERR_NONE;

		unique case (req_s1.op)
			ssb_pkg::OP_ARRIVAL: begin
				if (req_s1.server_idle && budget_pos) begin
					if (!req_s1.background && !active_q) begin
						nxt_active = 1'b1;
						nxt_res.arm_replenish = 1'b1;
					end
					nxt_res.start_task = 1'b1;
				end
			end
			ssb_pkg::OP_DISPATCH: begin
				if (!req_s1.background && !active_q) begin
					nxt_active = 1'b1;
					nxt_res.arm_replenish = 1'b1;
				end
				if (!req_s1.no_stop && !req_s1.background) begin
					nxt_res.arm_capacity = 1'b1;
					nxt_res.capacity_deadline = req_s1.now_us +
						(budget_pos ? budget_q : 32'd0);
				end
			end
			ssb_pkg::OP_CHARGE: begin
				if (!req_s1.background) begin
					nxt_budget = charge_budget;
					nxt_pend   = charge_pend;
				end
				if (!req_s1.job_end) begin
					if (nxt_budget <= 32'sd0) begin
						if (!req_s1.background && active_q) begin
							nxt_active = 1'b0;
							push       = 1'b1;
							push_amt   = nxt_pend;
							nxt_pend   = '0;
						end
						nxt_res.suspend_task = 1'b1;
					end
				end else if (req_s1.next_ready) begin
					nxt_res.start_task = 1'b1;
				end else if (!req_s1.background) begin
					if (!active_q) begin
						nxt_res.error_code = ssb_pkg::ERR_INACTIVE;
					end else begin
						nxt_active = 1'b0;
						push       = 1'b1;
						push_amt   = nxt_pend;
						nxt_pend   = '0;
					end
				end
			end
			ssb_pkg::OP_CAP_EXPIRED: begin
				nxt_active = 1'b0;
				nxt_budget = charge_budget;
				push       = 1'b1;
				push_amt   = charge_pend;
				nxt_pend   = '0;
			end
			ssb_pkg::OP_REPLENISH: begin
				if (count_q != '0) begin
					pop        = 1'b1;
					nxt_budget = rep_budget;
					// A budget that stays non-positive with nothing left to
					// come back and no activation pending is refilled.
					if (rep_budget <= 32'sd0 && count_q == CNT_W'(1) && !active_q) begin
						nxt_budget = {8'd0, capacity};
						nxt_res.forced_refill = 1'b1;
					end
				end else begin
					nxt_res.error_code = ssb_pkg::ERR_RING_EMPTY;
				end
				if (nxt_budget > 32'sd0 && req_s1.server_idle && req_s1.task_waiting) begin
					if (!active_q) begin
						nxt_active = 1'b1;
						nxt_res.arm_replenish = 1'b1;
					end
					nxt_res.start_task = 1'b1;
				end
			end
			ssb_pkg::OP_BLOCK: begin
				if (!req_s1.background) begin
					if (!active_q) begin
						nxt_res.error_code = ssb_pkg::ERR_INACTIVE;
					end else begin
						nxt_active = 1'b0;
						push       = 1'b1;
						push_amt   = pending_q;
						nxt_pend   = '0;
					end
				end
				nxt_budget = '0;
			end
			default: begin
			end
		endcase

		if (push && ring_full) begin
			nxt_res.error_code = ssb_pkg::ERR_RING_FULL;
		end
		if (nxt_res.arm_replenish) begin
			nxt_res.replenish_deadline = req_s1.now_us + {8'd0, period};
		end
		nxt_res.budget_left = nxt_budget;
	end

	always_ff @(posedge clk) begin
		if (fire && push && !ring_full) begin
			ring_mem[tail_q] <= push_amt;
		end
		if (q_pop) begin
			ring_rdata_q <= ring_mem[head_q];
			req_s1       <= q_req;
		end
		if (fire) begin
			res_q <= nxt_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q    <= {8'd0, ssb_pkg::RESET_CAPACITY};
			pending_q   <= '0;
			active_q    <= 1'b0;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (fire) begin
				budget_q  <= nxt_budget;
				pending_q <= nxt_pend;
				active_q  <= nxt_active;
				if (push && !ring_full) begin
					tail_q <= (tail_q == LAST_IDX) ? '0 : tail_q + IDX_W'(1);
				end
				if (pop) begin
					head_q <= (head_q == LAST_IDX) ? '0 : head_q + IDX_W'(1);
				end
				if (push && !ring_full && !pop) begin
					count_q <= count_q + CNT_W'(1);
				end else if (pop && !(push && !ring_full)) begin
					count_q <= count_q - CNT_W'(1);
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule
